### design/cbd_pkg.sv
// cbd_pkg: types and codes shared by the chunked body decoder
// depends on nothing; used by chunked_body_decoder_top
`timescale 1ns / 1ps

package cbd_pkg;

  // decoder phase
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_HALT    = 3'd5
  } phase_t;

  // result kind, carried on tuser
  typedef enum logic [2:0] {
    KIND_BODY     = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_BAD_SIZE = 3'd2,
    KIND_BAD_END  = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam int OUT_DEPTH = 3;

  // one queued result
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  body_byte;
    logic [31:0] body_length;
    logic        last;
  } result_t;

  // hex digit decode: valid flag in bit 4, value in bits 3:0
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

### design/chunked_body_decoder_top.sv
// chunked_body_decoder_top: streaming decoder for a chunked message body
// results are written into a three-word registered result queue and offered from its head
// input: one word per cycle while the queue holds at most one result; the input is
//   held off while two or more results wait, e.g. after a word giving two results
// reset: synchronous, clears phase, counters and the result queue
// depends on cbd_pkg
`timescale 1ns / 1ps

module chunked_body_decoder_top #(
  parameter int LENGTH_BITS = 32,
  parameter int TOTAL_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] body_byte, [39:8] body_length
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  // ---------------------------------------------------------------------------
  // decoder state
  // ---------------------------------------------------------------------------
  cbd_pkg::phase_t          phase, phase_next;
  logic [LENGTH_BITS-1:0]   chunk_remaining, chunk_remaining_next;
  logic [TOTAL_BITS-1:0]    byte_total, byte_total_next;
  logic                     final_chunk_seen, final_chunk_seen_next;

  // result queue: entry 0 is the head shown on the master side
  cbd_pkg::result_t         queue [cbd_pkg::OUT_DEPTH];
  cbd_pkg::result_t         queue_next [cbd_pkg::OUT_DEPTH];
  logic [1:0]               count, count_next;

  logic                     in_acc, out_acc;

  // ---------------------------------------------------------------------------
  // per-word decode
  // ---------------------------------------------------------------------------
  logic [4:0]               hex;
  logic [TOTAL_BITS-1:0]    total_step;     // total after this word's body byte
  logic [31:0]              total_report;   // clipped to 32 bits
  cbd_pkg::phase_t          phase_step;     // phase before the end flag applies
  logic                     emit_a;         // result from the byte itself
  cbd_pkg::kind_t           kind_a;
  logic [7:0]               byte_a;
  logic                     emit_trunc;     // early end result
  logic [1:0]               n_res;
  cbd_pkg::result_t         res0, res1;

  assign hex = cbd_pkg::hex_digit(s_axis_tdata);

  // the queue always has room for two results when we take a word, so the
  // input side never waits on the output handshake combinationally
  assign s_axis_tready = (count <= 2'd1);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign total_step = (phase == cbd_pkg::PH_DATA && byte_total != '1)
                    ? byte_total + TOTAL_BITS'(1) : byte_total;

  generate
    if (TOTAL_BITS > 32) begin : g_clip
      assign total_report = (|total_step[TOTAL_BITS-1:32]) ? 32'hffff_ffff
                                                           : total_step[31:0];
    end else begin : g_noclip
      assign total_report = 32'(total_step);
    end
  endgenerate

  // next state for one word
  always_comb begin
    phase_step           = phase;
    chunk_remaining_next = chunk_remaining;
    final_chunk_seen_next = final_chunk_seen;
    emit_a               = 1'b0;
    kind_a               = cbd_pkg::KIND_BODY;
    byte_a               = 8'd0;
    unique case (phase)
      cbd_pkg::PH_SIZE: begin
        if (hex[4]) begin
          // a digit that would shift set bits out of the length register
          if (chunk_remaining[LENGTH_BITS-1 -: 4] != 4'd0) begin
            emit_a     = 1'b1;
            kind_a     = cbd_pkg::KIND_OVERFLOW;
            phase_step = cbd_pkg::PH_HALT;
          end else begin
            chunk_remaining_next = {chunk_remaining[LENGTH_BITS-5:0], hex[3:0]};
          end
        end else if (s_axis_tdata == cbd_pkg::CHAR_CR) begin
          phase_step = cbd_pkg::PH_SIZE_LF;
        end else begin
          emit_a     = 1'b1;
          kind_a     = cbd_pkg::KIND_BAD_SIZE;
          phase_step = cbd_pkg::PH_HALT;
        end
      end
      cbd_pkg::PH_SIZE_LF: begin
        if (s_axis_tdata == cbd_pkg::CHAR_LF) begin
          if (chunk_remaining == '0) begin
            // zero-length chunk: still wants its CR LF terminator
            final_chunk_seen_next = 1'b1;
            phase_step            = cbd_pkg::PH_DATA_CR;
          end else begin
            phase_step = cbd_pkg::PH_DATA;
          end
        end else begin
          emit_a     = 1'b1;
          kind_a     = cbd_pkg::KIND_BAD_SIZE;
          phase_step = cbd_pkg::PH_HALT;
        end
      end
      cbd_pkg::PH_DATA: begin
        emit_a               = 1'b1;
        kind_a               = cbd_pkg::KIND_BODY;
        byte_a               = s_axis_tdata;
        chunk_remaining_next = chunk_remaining - LENGTH_BITS'(1);
        if (chunk_remaining == LENGTH_BITS'(1)) begin
          phase_step = cbd_pkg::PH_DATA_CR;
        end
      end
      cbd_pkg::PH_DATA_CR: begin
        if (s_axis_tdata == cbd_pkg::CHAR_CR) begin
          phase_step = cbd_pkg::PH_DATA_LF;
        end else begin
          emit_a     = 1'b1;
          kind_a     = cbd_pkg::KIND_BAD_END;
          phase_step = cbd_pkg::PH_HALT;
        end
      end
      cbd_pkg::PH_DATA_LF: begin
        if (s_axis_tdata == cbd_pkg::CHAR_LF) begin
          if (final_chunk_seen) begin
            emit_a     = 1'b1;
            kind_a     = cbd_pkg::KIND_DONE;
            phase_step = cbd_pkg::PH_HALT;
          end else begin
            chunk_remaining_next = '0;
            phase_step           = cbd_pkg::PH_SIZE;
          end
        end else begin
          emit_a     = 1'b1;
          kind_a     = cbd_pkg::KIND_BAD_END;
          phase_step = cbd_pkg::PH_HALT;
        end
      end
      default: begin
        phase_step = cbd_pkg::PH_HALT;
      end
    endcase
  end

  // end flag: report an unfinished message, then return to the reset state
  always_comb begin
    emit_trunc      = s_axis_tlast && (phase_step != cbd_pkg::PH_HALT);
    phase_next      = phase_step;
    byte_total_next = total_step;
    if (s_axis_tlast) begin
      phase_next      = cbd_pkg::PH_SIZE;
      byte_total_next = '0;
    end
  end

  // pack the results of this word; trunc comes second when the byte also gives a result
  always_comb begin
    res0.kind        = kind_a;
    res0.body_byte   = byte_a;
    res0.body_length = total_report;
    res0.last        = !emit_trunc;
    res1.kind        = cbd_pkg::KIND_TRUNC;
    res1.body_byte   = 8'd0;
    res1.body_length = total_report;
    res1.last        = 1'b1;
    n_res            = 2'(emit_a) + 2'(emit_trunc);
    if (!emit_a) begin
      res0 = res1;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue: shift out at the head, append behind the last valid word
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [1:0] base;
    base = count;
    for (int i = 0; i < cbd_pkg::OUT_DEPTH; i++) begin
      queue_next[i] = queue[i];
    end
    if (out_acc) begin
      for (int i = 0; i < cbd_pkg::OUT_DEPTH - 1; i++) begin
        queue_next[i] = queue[i+1];
      end
      base = count - 2'd1;
    end
    if (in_acc) begin
      for (int i = 0; i < cbd_pkg::OUT_DEPTH; i++) begin
        if (n_res != 2'd0 && 2'(i) == base) begin
          queue_next[i] = res0;
        end
        if (n_res == 2'd2 && 2'(i) == base + 2'd1) begin
          queue_next[i] = res1;
        end
      end
      count_next = base + n_res;
    end else begin
      count_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= cbd_pkg::PH_SIZE;
      chunk_remaining  <= '0;
      byte_total       <= '0;
      final_chunk_seen <= 1'b0;
      count            <= 2'd0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        phase <= phase_next;
        if (s_axis_tlast) begin
          chunk_remaining  <= '0;
          final_chunk_seen <= 1'b0;
        end else begin
          chunk_remaining  <= chunk_remaining_next;
          final_chunk_seen <= final_chunk_seen_next;
        end
        byte_total <= byte_total_next;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < cbd_pkg::OUT_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = {queue[0].body_length, queue[0].body_byte};
  assign m_axis_tuser  = queue[0].kind;
  assign m_axis_tlast  = queue[0].last;

`ifndef NO_ASSERTIONS
  // the queue only becomes full from a word that produced two results
  a_full_after_pair: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd3 && $past(count) != 2'd3) |-> $past(in_acc && n_res == 2'd2))
    else $error("result queue full without a preceding input word");

  // the end flag always brings the decoder back to its reset state
  a_eom_resets: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tlast) |=>
      (phase == cbd_pkg::PH_SIZE && byte_total == '0 && !final_chunk_seen))
    else $error("decoder not reset after end of message");

  // completion is never followed by another result of the same word
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == cbd_pkg::KIND_DONE) |-> m_axis_tlast)
    else $error("complete result not last of its run");

  // once the terminating chunk is seen only its terminator or halt can follow
  a_final_phase: assert property (@(posedge clk) disable iff (rst)
    final_chunk_seen |-> (phase == cbd_pkg::PH_DATA_CR || phase == cbd_pkg::PH_DATA_LF
                          || phase == cbd_pkg::PH_HALT))
    else $error("final chunk flag set in an unexpected phase");
`endif

endmodule
